// ----- rtl/tllbc_pkg.sv -----
package tllbc_pkg;

  localparam int DEF_ENTRIES = 16;

  localparam logic [1:0] ACT_GET  = 2'd0;
  localparam logic [1:0] ACT_PUT  = 2'd1;
  localparam logic [1:0] ACT_FREE = 2'd2;

  localparam logic [1:0] KIND_ACTIVE   = 2'd0;
  localparam logic [1:0] KIND_INACTIVE = 2'd1;
  localparam logic [1:0] KIND_MISS     = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_VICTIM = 2'd1;
  localparam logic [1:0] ST_PUT_ZERO  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] block_number;
    logic [3:0]  entry_index;
    logic [7:0]  free_request;
  } cmd_t;

  typedef struct packed {
    logic [3:0] entry;
    logic [1:0] lookup_kind;
    logic       need_page;
    logic       need_read;
    logic       page_freed;
    logic [4:0] freed_total;
    logic [1:0] status;
    logic       last;
  } res_t;

endpackage

// ----- rtl/two_list_lru_block_cache_core.sv -----
// Put and unused actions register their result word straight from the idle state; a get
// walks the active list and then the inactive list before it unlinks and relinks its entry.
// Freemem walks the inactive list from its tail and emits one word per freed page, then
// a total word; it waits while an earlier word has not been taken.
// The back end holds one item at a time until its last word is taken; a put that empties
// a count then unlinks and relinks its entry. A two-word queue decouples the input.
// Synchronous reset empties the queue, clears valid, count and page bits and
// relinks every entry onto the inactive list in index order.
module two_list_lru_block_cache_core import tllbc_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] block_number,
  input  logic [3:0]  entry_index,
  input  logic [7:0]  free_request,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  entry,
  output logic [1:0]  lookup_kind,
  output logic        need_page,
  output logic        need_read,
  output logic        page_freed,
  output logic [4:0]  freed_total,
  output logic [1:0]  status,
  output logic        last
);

  cmd_t in_cmd;
  cmd_t q_cmd;
  res_t res;
  logic q_valid;
  logic q_ready;

  assign in_cmd = '{action: action, block_number: block_number,
                    entry_index: entry_index, free_request: free_request};

  tllbc_front #(.DEPTH(2), .ENTRIES(ENTRIES)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  tllbc_back #(.ENTRIES(ENTRIES)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
  );

  assign entry       = res.entry;
  assign lookup_kind = res.lookup_kind;
  assign need_page   = res.need_page;
  assign need_read   = res.need_read;
  assign page_freed  = res.page_freed;
  assign freed_total = res.freed_total;
  assign status      = res.status;
  assign last        = res.last;

endmodule

// ----- rtl/tllbc_front.sv -----
module tllbc_front import tllbc_pkg::*; #(
  parameter int DEPTH   = 2,
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  cmd_t       in_cmd,
  output logic       q_valid,
  input  logic       q_ready,
  output cmd_t       q_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t           mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           push;
  logic           pop;
  cmd_t           norm;

  // Out-of-range free requests are clamped to the entry count here so the back end sees legal words.
  always_comb begin
    norm = in_cmd;
    if (in_cmd.action == ACT_FREE && in_cmd.free_request > 8'(ENTRIES)) begin
      norm.free_request = 8'(ENTRIES);
    end
  end

  assign in_ready = (count != (AW + 1)'(DEPTH));
  assign q_valid  = (count != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_cmd    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= norm;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

endmodule

// ----- rtl/tllbc_back.sv -----
module tllbc_back import tllbc_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  cmd_t q_cmd,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  localparam int NW = $clog2(ENTRIES + 2);
  localparam int EW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [NW-1:0] HA = NW'(ENTRIES);
  localparam logic [NW-1:0] HI = NW'(ENTRIES + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SRCH  = 7'b0000010,
    S_UNL   = 7'b0000100,
    S_LINK  = 7'b0001000,
    S_FREE  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_PAD   = 7'b1000000
  } state_t;

  state_t            state;
  cmd_t              cmd;
  logic [31:0]       block_tag [ENTRIES];
  logic [ENTRIES-1:0] tag_valid;
  logic [ENTRIES-1:0] page_present;
  logic [7:0]        ref_count [ENTRIES];
  logic [NW-1:0]     next_link [ENTRIES+2];
  logic [NW-1:0]     prev_link [ENTRIES+2];

  logic [NW-1:0]     cur;
  logic [NW-1:0]     head;
  logic [NW-1:0]     tgt;
  logic [CW-1:0]     steps;
  logic [CW-1:0]     freed;
  logic              in_inact;
  res_t              res;
  logic              res_pending;
  logic [NW-1:0]     nfirst;
  logic [EW-1:0]     ce;
  logic              cur_ent;
  logic [EW-1:0]     te;

  assign cur_ent = (cur < HA);
  assign ce      = cur[EW-1:0];
  assign te      = tgt[EW-1:0];
  assign nfirst  = next_link[head];
  assign q_ready = (state == S_IDLE) && !res_pending;
  assign out_valid = res_pending;
  assign out_res   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      res_pending  <= 1'b0;
      tag_valid    <= '0;
      page_present <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        ref_count[i] <= '0;
        next_link[i] <= (i + 1 < ENTRIES) ? NW'(i + 1) : HI;
        prev_link[i] <= (i == 0) ? HI : NW'(i - 1);
      end
      next_link[ENTRIES]   <= HA;
      prev_link[ENTRIES]   <= HA;
      next_link[ENTRIES+1] <= '0;
      prev_link[ENTRIES+1] <= NW'(ENTRIES - 1);
    end else begin
      if (res_pending && out_ready) begin
        res_pending <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid && !res_pending) begin
            cmd   <= q_cmd;
            steps <= '0;
            freed <= '0;
            res   <= '0;
            unique case (q_cmd.action)
              ACT_GET: begin
                cur      <= next_link[ENTRIES];
                in_inact <= 1'b0;
                state    <= S_SRCH;
              end
              ACT_PUT: begin
                res.entry <= q_cmd.entry_index;
                res.last  <= 1'b1;
                if ({28'd0, q_cmd.entry_index} >= 32'(ENTRIES) ||
                    ref_count[q_cmd.entry_index[EW-1:0]] == 8'd0) begin
                  res.status  <= ST_PUT_ZERO;
                  res_pending <= 1'b1;
                end else begin
                  ref_count[q_cmd.entry_index[EW-1:0]] <=
                    ref_count[q_cmd.entry_index[EW-1:0]] - 8'd1;
                  res_pending <= 1'b1;
                  if (ref_count[q_cmd.entry_index[EW-1:0]] == 8'd1) begin
                    tgt   <= NW'(q_cmd.entry_index[EW-1:0]);
                    head  <= HI;
                    state <= S_UNL;
                  end
                end
              end
              ACT_FREE: begin
                cur   <= prev_link[ENTRIES+1];
                state <= S_FREE;
              end
              default: begin
                res.last    <= 1'b1;
                res_pending <= 1'b1;
              end
            endcase
          end
        end
        S_SRCH: begin
          if (steps == CW'(ENTRIES) || cur == (in_inact ? HI : HA)) begin
            if (!in_inact) begin
              in_inact <= 1'b1;
              cur      <= next_link[ENTRIES+1];
              steps    <= '0;
            end else if (prev_link[ENTRIES+1] >= HA) begin
              res.lookup_kind <= KIND_MISS;
              res.status      <= ST_NO_VICTIM;
              res.last        <= 1'b1;
              res_pending     <= 1'b1;
              state           <= S_IDLE;
            end else begin
              tgt  <= prev_link[ENTRIES+1];
              head <= HA;
              res.entry       <= 4'(prev_link[ENTRIES+1]);
              res.lookup_kind <= KIND_MISS;
              res.need_read   <= 1'b1;
              res.need_page   <= !page_present[prev_link[ENTRIES+1][EW-1:0]];
              page_present[prev_link[ENTRIES+1][EW-1:0]] <= 1'b1;
              block_tag[prev_link[ENTRIES+1][EW-1:0]]    <= cmd.block_number;
              tag_valid[prev_link[ENTRIES+1][EW-1:0]]    <= 1'b1;
              state <= S_UNL;
            end
          end else if (cur_ent && tag_valid[ce] && block_tag[ce] == cmd.block_number) begin
            tgt       <= cur;
            head      <= HA;
            res.entry <= 4'(cur);
            if (in_inact) begin
              res.lookup_kind <= KIND_INACTIVE;
              res.need_read   <= 1'b1;
              res.need_page   <= !page_present[ce];
              page_present[ce] <= 1'b1;
            end
            state <= S_UNL;
          end else begin
            cur   <= next_link[cur];
            steps <= steps + 1'b1;
          end
        end
        S_UNL: begin
          next_link[prev_link[tgt]] <= next_link[tgt];
          prev_link[next_link[tgt]] <= prev_link[tgt];
          state <= S_LINK;
        end
        S_LINK: begin
          next_link[tgt]    <= nfirst;
          prev_link[nfirst] <= tgt;
          prev_link[tgt]    <= head;
          next_link[head]   <= tgt;
          if (head == HA) begin
            res.last <= 1'b1;
            if (ref_count[te] == 8'hFF) begin
              res.status <= ST_OVERFLOW;
            end else begin
              ref_count[te] <= ref_count[te] + 8'd1;
            end
            res_pending <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_FREE: begin
          if (!res_pending) begin
            if (cur == HI || {{(8-CW){1'b0}}, freed} >= cmd.free_request ||
                steps == CW'(ENTRIES)) begin
              res             <= '0;
              res.freed_total <= 5'(freed);
              res.last        <= 1'b1;
              res_pending     <= 1'b1;
              state           <= S_IDLE;
            end else begin
              if (cur_ent && ref_count[ce] == 8'd0 && page_present[ce]) begin
                page_present[ce] <= 1'b0;
                freed            <= freed + 1'b1;
                res              <= '0;
                res.entry        <= 4'(cur);
                res.page_freed   <= 1'b1;
                res_pending      <= 1'b1;
              end
              cur   <= prev_link[cur];
              steps <= steps + 1'b1;
            end
          end
        end
        S_EMIT: state <= S_IDLE;
        S_PAD:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
